>>> rtl/first_fit_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ffba assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ffba assertion failed");

`endif

>>> rtl/ffba_pkg.sv
// Shared types and codes of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

    localparam int LEN_W = 20;
    localparam int OFS_W = 20;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic             command;
        logic [LEN_W-1:0] request_size;
        logic [OFS_W-1:0] payload_offset;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [OFS_W-1:0] granted_offset;
    } rsp_t;

endpackage

>>> rtl/ffba_table.sv
// Block table memory: one write port, one read port with registered data.
// Depends on nothing; entries hold {header start, payload length}.
module ffba_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 40
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write one entry per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ffba_ctrl.sv
// Request sequencer: scans the table, then shifts entries where needed to insert or remove.
// Depends on ffba_pkg, ffba_table and the allocator macro header.
`include "first_fit_block_allocator_macros.svh"
module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic res_valid,
    input  logic res_ready,
    output rsp_t res
);

    localparam int SW = $clog2(POOL_BYTES);
    localparam int EW = SW + 1;
    localparam int NW = ((EW > OFS_W + 1) ? EW : OFS_W + 1) + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int DW = SW + LEN_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_CMP = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_PUT      = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic             cmd_reg, cmd_next;
    logic [LEN_W-1:0] size_reg, size_next;
    logic [OFS_W-1:0] poff_reg, poff_next;
    logic [NW-1:0]    need_reg, need_next;
    logic [NW-1:0]    prev_end_reg, prev_end_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    count_reg, count_next;
    rsp_t             rsp_reg, rsp_next;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic [IW-1:0]    mem_raddr;
    logic [DW-1:0]    mem_rdata;

    logic [NW-1:0]    hdr;
    logic [NW-1:0]    pool;
    logic [NW-1:0]    need_in;
    logic [NW-1:0]    start_ext;
    logic [NW-1:0]    end_next;
    logic [NW-1:0]    grant_sum;
    logic [CW-1:0]    shift_src;
    logic             fit_gap;
    logic             fit_tail;
    logic             hit_free;

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW),
        .DW    (DW)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Address arithmetic on the entry just read
    assign hdr       = NW'(HEADER_BYTES);
    assign pool      = NW'(POOL_BYTES);
    assign need_in   = NW'(s_req.request_size) + hdr;
    assign start_ext = NW'(mem_rdata[DW-1:LEN_W]);
    assign end_next  = start_ext + hdr + NW'(mem_rdata[LEN_W-1:0]);
    assign fit_gap   = start_ext >= (prev_end_reg + need_reg);
    assign fit_tail  = (prev_end_reg + need_reg) <= pool;
    assign hit_free  = (start_ext + hdr) == NW'(poff_reg);
    assign grant_sum = prev_end_reg + hdr;
    assign shift_src = (cmd_reg == CMD_FREE) ? (idx_reg + CW'(1)) : (idx_reg - CW'(1));

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        size_next     = size_reg;
        poff_next     = poff_reg;
        need_next     = need_reg;
        prev_end_next = prev_end_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        rsp_next      = rsp_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[IW-1:0];
        mem_wdata     = mem_rdata;
        mem_raddr     = idx_reg[IW-1:0];
        s_ready       = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next      = s_req.command;
                    size_next     = s_req.request_size;
                    poff_next     = s_req.payload_offset;
                    need_next     = need_in;
                    prev_end_next = '0;
                    idx_next      = '0;
                    rsp_next      = '{status: ST_OK, granted_offset: '0};
                    state_next    = S_SCAN_RD;
                    if (s_req.command == CMD_ALLOC) begin
                        if (s_req.request_size == '0 || need_in > pool) begin
                            rsp_next.status = ST_BAD_SIZE;
                            state_next      = S_DONE;
                        end else if (count_reg == CW'(MAX_BLOCKS)) begin
                            rsp_next.status = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                // End of table: append or report
                if (idx_reg == count_reg) begin
                    if (cmd_reg == CMD_FREE) begin
                        rsp_next.status = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end else if (fit_tail) begin
                        rsp_next.granted_offset = grant_sum[OFS_W-1:0];
                        pos_next                = count_reg;
                        state_next              = S_PUT;
                    end else begin
                        rsp_next.status = ST_NO_SPACE;
                        state_next      = S_DONE;
                    end
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (cmd_reg == CMD_ALLOC) begin
                    if (fit_gap) begin
                        rsp_next.granted_offset = grant_sum[OFS_W-1:0];
                        pos_next                = idx_reg;
                        idx_next                = count_reg;
                        state_next              = S_SHIFT_RD;
                    end else begin
                        prev_end_next = end_next;
                        idx_next      = idx_reg + CW'(1);
                        state_next    = S_SCAN_RD;
                    end
                end else if (hit_free) begin
                    if ((idx_reg + CW'(1)) < count_reg) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                mem_raddr  = shift_src[IW-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // Move the neighbor entry into the slot at idx
                mem_we = 1'b1;
                if (cmd_reg == CMD_ALLOC) begin
                    idx_next = idx_reg - CW'(1);
                    if ((idx_reg - CW'(1)) == pos_reg) begin
                        state_next = S_PUT;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end else begin
                    idx_next = idx_reg + CW'(1);
                    if ((idx_reg + CW'(2)) < count_reg) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end
            end
            S_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[IW-1:0];
                mem_wdata  = {prev_end_reg[SW-1:0], size_reg};
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = rsp_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        poff_reg     <= poff_next;
        need_reg     <= need_next;
        prev_end_reg <= prev_end_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        rsp_reg      <= rsp_next;
    end

    `FFBA_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_BLOCKS))
    `FFBA_ASSERT_IMP(a_write_states, aclk, aresetn, mem_we, state_reg == S_SHIFT_WR || state_reg == S_PUT)
    `FFBA_ASSERT_IMP(a_put_is_ok, aclk, aresetn, state_reg == S_PUT, rsp_reg.status == ST_OK)
    `FFBA_ASSERT_IMP(a_scan_in_table, aclk, aresetn, state_reg == S_SCAN_RD, idx_reg <= count_reg)
    `FFBA_ASSERT_NXT(a_idle_holds_count, aclk, aresetn, state_reg == S_IDLE, $stable(count_reg))

endmodule

>>> rtl/first_fit_block_allocator.sv
// A bad size or a full table is reported without a table walk. Otherwise the request
// scans the table entry by entry up to a fit, a match or the table end, shifts entries
// where needed to open or close a slot, writes any new entry and hands the result to the
// output register. One request at a time, taken again as soon as the result moves to the
// output register; the walk over the block table sets the rate.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    logic res_valid;
    logic res_ready;
    rsp_t res;
    logic m_valid_reg;
    rsp_t m_rsp_reg;

    ffba_ctrl #(
        .POOL_BYTES   (POOL_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a result beat when the output slot is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // Hold the payload until the beat is taken
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_rsp_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule
